/* design/kbcs_pkg.sv */
// ---------------------------------------------------------------------------
// kbcs_pkg - shared types and constants of the keyed byte chain scrambler
// Holds the key geometry, the operation code and the item record that moves
// from the input register of the top level into the datapath.
// ---------------------------------------------------------------------------
package kbcs_pkg;

   localparam int BYTE_W    = 8;
   localparam int KEY_W     = 64;
   // key bytes in use; bytes at this index and above are ignored
   localparam int KEY_BYTES = 8;
   localparam int ADD_W     = 5;
   localparam int ROT_W     = 3;

   typedef enum logic [0:0] {
      OP_SCRAMBLE   = 1'b0,
      OP_UNSCRAMBLE = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type         opcode;
      logic               start_of_run;
      logic [BYTE_W-1:0]  seed;
      logic [BYTE_W-1:0]  data_byte;
   } item_type;

endpackage

/* design/kbcs_core.sv */
// ---------------------------------------------------------------------------
// kbcs_core - scramble / unscramble datapath
// Combinational: picks the chain byte (seed on start of run), runs the keyed
// add/rotate chain forward or backward and returns the result byte and the
// chain byte that the next item sees.
// ---------------------------------------------------------------------------
module kbcs_core (
   input  logic [kbcs_pkg::KEY_W-1:0]  key_word,
   input  kbcs_pkg::item_type          item,
   input  logic [kbcs_pkg::BYTE_W-1:0] chain_byte,
   output logic [kbcs_pkg::BYTE_W-1:0] out_byte,
   output logic [kbcs_pkg::BYTE_W-1:0] next_chain
);

   function automatic logic [kbcs_pkg::BYTE_W-1:0] rotl8(
      input logic [kbcs_pkg::BYTE_W-1:0] v,
      input logic [kbcs_pkg::ROT_W-1:0]  s
   );
      logic [2*kbcs_pkg::BYTE_W-1:0] w;
      w = {v, v} << s;
      return w[2*kbcs_pkg::BYTE_W-1:kbcs_pkg::BYTE_W];
   endfunction

   function automatic logic [kbcs_pkg::BYTE_W-1:0] rotr8(
      input logic [kbcs_pkg::BYTE_W-1:0] v,
      input logic [kbcs_pkg::ROT_W-1:0]  s
   );
      logic [2*kbcs_pkg::BYTE_W-1:0] w;
      w = {v, v} >> s;
      return w[kbcs_pkg::BYTE_W-1:0];
   endfunction

   logic [kbcs_pkg::BYTE_W-1:0] chain_sel;
   logic [kbcs_pkg::BYTE_W-1:0] enc;
   logic [kbcs_pkg::BYTE_W-1:0] dec;

   assign chain_sel = item.start_of_run ? item.seed : chain_byte;

   // forward chain: xor, full add, then rotate-and-add per key byte
   always_comb begin
      logic [kbcs_pkg::BYTE_W-1:0] v;
      logic [kbcs_pkg::BYTE_W-1:0] k;
      v = (item.data_byte ^ chain_sel) + key_word[kbcs_pkg::BYTE_W-1:0];
      for (int i = 1; i < kbcs_pkg::KEY_BYTES; i++) begin
         k = key_word[kbcs_pkg::BYTE_W*i +: kbcs_pkg::BYTE_W];
         v = rotl8(v, k[kbcs_pkg::BYTE_W-1 -: kbcs_pkg::ROT_W])
             + {{(kbcs_pkg::BYTE_W-kbcs_pkg::ADD_W){1'b0}}, k[kbcs_pkg::ADD_W-1:0]};
      end
      enc = v;
   end

   // inverse chain: undo the key bytes last to first
   always_comb begin
      logic [kbcs_pkg::BYTE_W-1:0] v;
      logic [kbcs_pkg::BYTE_W-1:0] k;
      v = item.data_byte;
      for (int i = kbcs_pkg::KEY_BYTES - 1; i >= 1; i--) begin
         k = key_word[kbcs_pkg::BYTE_W*i +: kbcs_pkg::BYTE_W];
         v = rotr8(v - {{(kbcs_pkg::BYTE_W-kbcs_pkg::ADD_W){1'b0}},
                        k[kbcs_pkg::ADD_W-1:0]},
                   k[kbcs_pkg::BYTE_W-1 -: kbcs_pkg::ROT_W]);
      end
      v   = v - key_word[kbcs_pkg::BYTE_W-1:0];
      dec = v ^ chain_sel;
   end

   always_comb begin
      case (item.opcode)
         kbcs_pkg::OP_SCRAMBLE: begin
            out_byte   = enc;
            next_chain = enc;
         end
         kbcs_pkg::OP_UNSCRAMBLE: begin
            out_byte   = dec;
            next_chain = item.data_byte;
         end
         default: begin
            out_byte   = enc;
            next_chain = enc;
         end
      endcase
   end

endmodule

/* design/keyed_byte_chain_scrambler.sv */
// ---------------------------------------------------------------------------
// keyed_byte_chain_scrambler - keyed byte scrambler with ciphertext chaining
// Two register stages: an input register and a result register, with the
// keyed add/rotate chain between them.
// ---------------------------------------------------------------------------
// The block takes one byte per clock and delivers one result byte per byte,
// in order; an accepted byte moves from the input register to the result
// register when that is free, and the pipe keeps streaming as long as
// rsp_tready is high. The clock is set by the chain of one xor, one full add
// and KEY_BYTES-1 rotate-and-add steps between the input and result
// registers, which also closes the chain-byte loop from one byte to the next.
// The key is written through csr_valid/csr_data (always ready); the user must
// write it only while no byte is in flight (not enforced by the block). The
// chain byte starts at zero after reset; start_of_run reloads it from seed.
module keyed_byte_chain_scrambler (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [15:0]                 req_tdata,   // seed[7:0], data_byte[15:8]
   input  logic [1:0]                  req_tuser,   // opcode[0], start_of_run[1]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,   // out_byte[7:0]
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [kbcs_pkg::KEY_W-1:0]  csr_data
);

   logic [kbcs_pkg::KEY_W-1:0]  key_ff;
   logic [kbcs_pkg::BYTE_W-1:0] chain_ff;
   logic [kbcs_pkg::BYTE_W-1:0] chain_in;
   logic                        s1_valid_ff;
   kbcs_pkg::item_type          s1_ff;
   kbcs_pkg::item_type          s1_in;
   logic                        rsp_valid_ff;
   logic [kbcs_pkg::BYTE_W-1:0] rsp_data_ff;
   logic [kbcs_pkg::BYTE_W-1:0] rsp_data_in;
   logic                        advance;

   assign s1_in.opcode       = kbcs_pkg::opcode_type'(req_tuser[0]);
   assign s1_in.start_of_run = req_tuser[1];
   assign s1_in.seed         = req_tdata[7:0];
   assign s1_in.data_byte    = req_tdata[15:8];

   // result register is free or is being emptied this cycle
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   kbcs_core u_core (
      .key_word   (key_ff),
      .item       (s1_ff),
      .chain_byte (chain_ff),
      .out_byte   (rsp_data_in),
      .next_chain (chain_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         chain_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            key_ff <= csr_data;
         end
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         // commit the chain only when the item moves into the result register
         if (advance && s1_valid_ff) begin
            chain_ff <= chain_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_ff <= s1_in;
      end
      if (advance && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while both stages are stalled");

   a_scramble_chain: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_valid_ff && s1_ff.opcode == kbcs_pkg::OP_SCRAMBLE)
      |=> (chain_ff == rsp_data_ff))
      else $error("scramble did not chain on its result byte");

   a_unscramble_chain: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_valid_ff && s1_ff.opcode == kbcs_pkg::OP_UNSCRAMBLE)
      |=> (chain_ff == $past(s1_ff.data_byte)))
      else $error("unscramble did not chain on the incoming byte");
`endif

endmodule
